@@ hdl/sfle_pkg.sv @@
// ----------------------------------------------------------------------------
// sfle_pkg
// Shared codes, widths and controller/datapath types of the field line editor.
// ----------------------------------------------------------------------------
`default_nettype none

package sfle_pkg;

   localparam int OP_W   = 2;
   localparam int ADDR_W = 10;
   localparam int CHAR_W = 8;
   localparam int LEN_W  = 8;
   localparam int KEY_W  = 4;
   localparam int TERM_W = 3;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 48;

   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_START = 2'd2;
   localparam logic [OP_W-1:0] OP_KEY   = 2'd3;

   localparam logic [KEY_W-1:0] KEY_CHAR   = 4'd0;
   localparam logic [KEY_W-1:0] KEY_ENTER  = 4'd1;
   localparam logic [KEY_W-1:0] KEY_PGUP   = 4'd2;
   localparam logic [KEY_W-1:0] KEY_PGDN   = 4'd3;
   localparam logic [KEY_W-1:0] KEY_BKSP   = 4'd4;
   localparam logic [KEY_W-1:0] KEY_DEL    = 4'd5;
   localparam logic [KEY_W-1:0] KEY_LEFT   = 4'd6;
   localparam logic [KEY_W-1:0] KEY_RIGHT  = 4'd7;
   localparam logic [KEY_W-1:0] KEY_END    = 4'd8;
   localparam logic [KEY_W-1:0] KEY_HOME   = 4'd9;
   localparam logic [KEY_W-1:0] KEY_UP     = 4'd10;
   localparam logic [KEY_W-1:0] KEY_DOWN   = 4'd11;
   localparam logic [KEY_W-1:0] KEY_BREAK  = 4'd12;
   localparam logic [KEY_W-1:0] KEY_ESCAPE = 4'd13;

   localparam logic [TERM_W-1:0] TERM_NONE   = 3'd0;
   localparam logic [TERM_W-1:0] TERM_ENTER  = 3'd1;
   localparam logic [TERM_W-1:0] TERM_PGUP   = 3'd2;
   localparam logic [TERM_W-1:0] TERM_PGDN   = 3'd3;
   localparam logic [TERM_W-1:0] TERM_ESCAPE = 3'd4;

   localparam logic [CHAR_W-1:0] SPACE_CODE = 8'd32;
   localparam logic [CHAR_W-1:0] PRINT_LO   = 8'd32;
   localparam logic [CHAR_W-1:0] PRINT_HI   = 8'd126;

   typedef enum logic [11:0] {
      S_WAIT_CLR    = 12'b0000_0000_0001,
      S_IDLE        = 12'b0000_0000_0010,
      S_DECODE      = 12'b0000_0000_0100,
      S_READ_WAIT   = 12'b0000_0000_1000,
      S_SCROLL_WAIT = 12'b0000_0001_0000,
      S_FILL_WAIT   = 12'b0000_0010_0000,
      S_INS         = 12'b0000_0100_0000,
      S_INS_WAIT    = 12'b0000_1000_0000,
      S_PUT         = 12'b0001_0000_0000,
      S_DEL         = 12'b0010_0000_0000,
      S_DEL_WAIT    = 12'b0100_0000_0000,
      S_FINISH      = 12'b1000_0000_0000
   } state_type;

   typedef struct packed {
      logic accept;
      logic decode;
      logic read_cap;
      logic scroll_go;
      logic fill_go;
      logic ins_go;
      logic put;
      logic del_go;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic is_read;
      logic ins_ok;
      logic need_scroll;
      logic scroll_blocked;
      logic del_ok;
      logic busy;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

@@ hdl/sfle_ram.sv @@
// ----------------------------------------------------------------------------
// sfle_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sfle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

@@ hdl/sfle_ctrl.sv @@
// ----------------------------------------------------------------------------
// sfle_ctrl
// Sequencer: steps each item through decode, screen moves and result load.
// ----------------------------------------------------------------------------
`default_nettype none

module sfle_ctrl
   import sfle_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   output logic         req_tready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_WAIT_CLR: begin
            if (!sts.busy) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            if (sts.is_read) begin
               state_in = S_READ_WAIT;
            end else if (sts.ins_ok) begin
               if (!sts.need_scroll) begin
                  state_in = S_INS;
               end else if (sts.scroll_blocked) begin
                  state_in = S_FINISH;
               end else begin
                  cmd.scroll_go = 1'b1;
                  state_in      = S_SCROLL_WAIT;
               end
            end else if (sts.del_ok) begin
               state_in = S_DEL;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_READ_WAIT: begin
            cmd.read_cap = 1'b1;
            state_in     = S_FINISH;
         end
         S_SCROLL_WAIT: begin
            if (!sts.busy) begin
               cmd.fill_go = 1'b1;
               state_in    = S_FILL_WAIT;
            end
         end
         S_FILL_WAIT: begin
            if (!sts.busy) state_in = S_INS;
         end
         S_INS: begin
            cmd.ins_go = 1'b1;
            state_in   = S_INS_WAIT;
         end
         S_INS_WAIT: begin
            if (!sts.busy) state_in = S_PUT;
         end
         S_PUT: begin
            cmd.put  = 1'b1;
            state_in = S_FINISH;
         end
         S_DEL: begin
            cmd.del_go = 1'b1;
            state_in   = S_DEL_WAIT;
         end
         S_DEL_WAIT: begin
            if (!sts.busy) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_WAIT_CLR;
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_WAIT_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/sfle_dp.sv @@
// ----------------------------------------------------------------------------
// sfle_dp
// Datapath: field registers, cell copy/fill engine, screen RAM, result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sfle_dp
   import sfle_pkg::*;
#(
   parameter int SCREEN_COLS = 64,
   parameter int SCREEN_ROWS = 16,
   parameter int MAX_FIELD   = 240
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output sts_type                    sts,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [OP_W-1:0]       req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int CELLS  = SCREEN_COLS * SCREEN_ROWS;
   localparam int CELL_W = $clog2(CELLS);
   localparam int CNT_W  = $clog2(CELLS + 1);

   logic [OP_W-1:0]   op_ff, op_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [CHAR_W-1:0] ch_ff, ch_in;
   logic [ADDR_W-1:0] fs_ff, fs_in;
   logic [LEN_W-1:0]  fl_ff, fl_in;
   logic [LEN_W-1:0]  co_ff, co_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic              run_ff, run_in;

   logic [CELL_W-1:0] start_ff, start_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [CELL_W-1:0] cur_ff, cur_in;

   logic [CELL_W-1:0] src_ff, src_in;
   logic [CELL_W-1:0] dst_ff, dst_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              fill_ff, fill_in;
   logic              down_ff, down_in;
   logic              pend_ff, pend_in;
   logic [CELL_W-1:0] pdst_ff, pdst_in;

   logic [CHAR_W-1:0] rd_ff, rd_in;
   logic              done_ff, done_in;
   logic [TERM_W-1:0] term_ff, term_in;
   logic              brk_ff, brk_in;
   logic              cancel_ff, cancel_in;

   logic                  out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;

   logic              ram_we;
   logic [CELL_W-1:0] ram_waddr;
   logic [CHAR_W-1:0] ram_wdata;
   logic [CELL_W-1:0] ram_raddr;
   logic [CHAR_W-1:0] ram_rdata;

   logic [CELL_W-1:0] end_c;
   logic              addr_ok;
   logic [CELL_W-1:0] fs_c;
   logic [CELL_W-1:0] room_c;
   logic [LEN_W-1:0]  fl_m;
   logic [LEN_W-1:0]  fl_c;
   logic [LEN_W-1:0]  co_c;
   logic [CELL_W:0]   down_t;
   logic              running;

   assign end_c   = start_ff + CELL_W'(len_ff);
   assign addr_ok = 32'(addr_ff) < CELLS;
   assign running = (cnt_ff != '0);
   assign down_t  = (CELL_W + 1)'(cur_ff) + (CELL_W + 1)'(SCREEN_COLS);

   always_comb begin
      fs_c   = (32'(fs_ff) > CELLS - 1) ? CELL_W'(CELLS - 1) : CELL_W'(fs_ff);
      room_c = CELL_W'(CELLS - 1) - fs_c;
      fl_m   = (32'(fl_ff) > MAX_FIELD) ? LEN_W'(MAX_FIELD) : fl_ff;
      fl_c   = (32'(fl_m) > 32'(room_c)) ? LEN_W'(room_c) : fl_m;
      co_c   = (co_ff > fl_c) ? fl_c : co_ff;
   end

   always_comb begin
      sts.is_read        = (op_ff == OP_READ);
      sts.ins_ok         = (op_ff == OP_KEY) && (key_ff == KEY_CHAR) &&
                           (ch_ff >= PRINT_LO) && (ch_ff <= PRINT_HI) &&
                           (32'(len_ff) < MAX_FIELD);
      sts.need_scroll    = 32'(end_c) >= CELLS - 1;
      sts.scroll_blocked = 32'(start_ff) < SCREEN_COLS;
      sts.del_ok         = (op_ff == OP_KEY) &&
                           ((key_ff == KEY_DEL) ||
                            ((key_ff == KEY_BKSP) && (cur_ff != start_ff)));
      sts.busy           = running || pend_ff;
      sts.out_free       = !out_valid_ff || rsp_tready;
   end

   always_comb begin
      op_in  = op_ff;
      addr_in = addr_ff;
      ch_in  = ch_ff;
      fs_in  = fs_ff;
      fl_in  = fl_ff;
      co_in  = co_ff;
      key_in = key_ff;
      run_in = run_ff;
      start_in = start_ff;
      len_in   = len_ff;
      cur_in   = cur_ff;
      src_in  = src_ff;
      dst_in  = dst_ff;
      cnt_in  = cnt_ff;
      fill_in = fill_ff;
      down_in = down_ff;
      pend_in = 1'b0;
      pdst_in = dst_ff;
      rd_in     = rd_ff;
      done_in   = done_ff;
      term_in   = term_ff;
      brk_in    = brk_ff;
      cancel_in = cancel_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;

      if (cmd.accept) begin
         op_in   = req_tuser;
         addr_in = req_tdata[9:0];
         ch_in   = req_tdata[17:10];
         fs_in   = req_tdata[27:18];
         fl_in   = req_tdata[35:28];
         co_in   = req_tdata[43:36];
         key_in  = req_tdata[47:44];
         run_in  = req_tdata[48];
      end

      if (cmd.decode) begin
         rd_in     = '0;
         done_in   = 1'b0;
         term_in   = TERM_NONE;
         brk_in    = 1'b0;
         cancel_in = 1'b0;
         unique case (op_ff)
            OP_WRITE, OP_READ: begin
            end
            OP_START: begin
               start_in = fs_c;
               len_in   = fl_c;
               cur_in   = fs_c + CELL_W'(co_c);
            end
            OP_KEY: begin
               unique case (key_ff)
                  KEY_ENTER: begin
                     done_in = 1'b1;
                     term_in = TERM_ENTER;
                  end
                  KEY_PGUP: begin
                     done_in = 1'b1;
                     term_in = TERM_PGUP;
                  end
                  KEY_PGDN: begin
                     done_in = 1'b1;
                     term_in = TERM_PGDN;
                  end
                  KEY_BKSP, KEY_LEFT: begin
                     if (cur_ff != start_ff) cur_in = cur_ff - 1'b1;
                  end
                  KEY_RIGHT: begin
                     if (cur_ff != end_c) cur_in = cur_ff + 1'b1;
                  end
                  KEY_END:  cur_in = end_c;
                  KEY_HOME: cur_in = start_ff;
                  KEY_UP: begin
                     if (32'(cur_ff) < 32'(start_ff) + SCREEN_COLS) begin
                        cur_in = start_ff;
                     end else begin
                        cur_in = cur_ff - CELL_W'(SCREEN_COLS);
                     end
                  end
                  KEY_DOWN: begin
                     if (down_t > (CELL_W + 1)'(end_c)) begin
                        cur_in = end_c;
                     end else begin
                        cur_in = down_t[CELL_W-1:0];
                     end
                  end
                  KEY_BREAK: begin
                     brk_in    = run_ff;
                     cancel_in = 1'b1;
                     done_in   = 1'b1;
                     term_in   = TERM_ESCAPE;
                  end
                  KEY_ESCAPE: begin
                     cancel_in = 1'b1;
                     done_in   = 1'b1;
                     term_in   = TERM_ESCAPE;
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end

      if (cmd.read_cap) begin
         rd_in = addr_ok ? ram_rdata : '0;
      end

      if (running) begin
         cnt_in = cnt_ff - 1'b1;
         if (fill_ff) begin
            dst_in = dst_ff + 1'b1;
         end else begin
            pend_in = 1'b1;
            pdst_in = dst_ff;
            if (down_ff) begin
               src_in = src_ff - 1'b1;
               dst_in = dst_ff - 1'b1;
            end else begin
               src_in = src_ff + 1'b1;
               dst_in = dst_ff + 1'b1;
            end
         end
      end

      if (cmd.scroll_go) begin
         src_in  = CELL_W'(SCREEN_COLS);
         dst_in  = '0;
         cnt_in  = CNT_W'(CELLS - SCREEN_COLS);
         fill_in = 1'b0;
         down_in = 1'b0;
      end

      if (cmd.fill_go) begin
         dst_in   = CELL_W'(CELLS - SCREEN_COLS);
         cnt_in   = CNT_W'(SCREEN_COLS);
         fill_in  = 1'b1;
         start_in = start_ff - CELL_W'(SCREEN_COLS);
         cur_in   = cur_ff - CELL_W'(SCREEN_COLS);
      end

      if (cmd.ins_go) begin
         src_in  = end_c - 1'b1;
         dst_in  = end_c;
         cnt_in  = CNT_W'(end_c - cur_ff);
         fill_in = 1'b0;
         down_in = 1'b1;
      end

      if (cmd.put) begin
         cur_in = cur_ff + 1'b1;
         len_in = len_ff + 1'b1;
      end

      if (cmd.del_go && (end_c != cur_ff)) begin
         src_in  = cur_ff + 1'b1;
         dst_in  = cur_ff;
         cnt_in  = CNT_W'(end_c - cur_ff);
         fill_in = 1'b0;
         down_in = 1'b0;
         len_in  = len_ff - 1'b1;
      end

      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
         out_data_in  = '0;
         out_data_in[7:0]   = rd_ff;
         out_data_in[17:8]  = ADDR_W'(cur_ff);
         out_data_in[27:18] = ADDR_W'(start_ff);
         out_data_in[35:28] = len_ff;
         out_data_in[36]    = done_ff;
         out_data_in[39:37] = term_ff;
         out_data_in[40]    = brk_ff;
         out_data_in[41]    = cancel_ff;
      end
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = pdst_ff;
      ram_wdata = ram_rdata;
      priority if (pend_ff) begin
         ram_we = 1'b1;
      end else if (running && fill_ff) begin
         ram_we    = 1'b1;
         ram_waddr = dst_ff;
         ram_wdata = SPACE_CODE;
      end else if (cmd.decode && (op_ff == OP_WRITE) && addr_ok) begin
         ram_we    = 1'b1;
         ram_waddr = CELL_W'(addr_ff);
         ram_wdata = ch_ff;
      end else if (cmd.put) begin
         ram_we    = 1'b1;
         ram_waddr = cur_ff;
         ram_wdata = ch_ff;
      end
      ram_raddr = running ? src_ff : CELL_W'(addr_ff);
   end

   sfle_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (CELLS)
   ) u_ram (
      .clock      (clock),
      .wr_en      (ram_we),
      .wr_addr    (ram_waddr),
      .wr_data    (ram_wdata),
      .rd_addr    (ram_raddr),
      .rd_data_ff (ram_rdata)
   );

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      addr_ff <= addr_in;
      ch_ff   <= ch_in;
      fs_ff   <= fs_in;
      fl_ff   <= fl_in;
      co_ff   <= co_in;
      key_ff  <= key_in;
      run_ff  <= run_in;
      src_ff  <= src_in;
      pdst_ff <= pdst_in;
      down_ff <= down_in;
      rd_ff     <= rd_in;
      done_ff   <= done_in;
      term_ff   <= term_in;
      brk_ff    <= brk_in;
      cancel_ff <= cancel_in;
      out_data_ff <= out_data_in;
      if (reset) begin
         start_ff     <= '0;
         len_ff       <= '0;
         cur_ff       <= '0;
         dst_ff       <= '0;
         cnt_ff       <= CNT_W'(CELLS);
         fill_ff      <= 1'b1;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         start_ff     <= start_in;
         len_ff       <= len_in;
         cur_ff       <= cur_in;
         dst_ff       <= dst_in;
         cnt_ff       <= cnt_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

`default_nettype wire

@@ hdl/screen_field_line_editor.sv @@
// ----------------------------------------------------------------------------
// screen_field_line_editor
// Character screen with one edit field, edited one key item at a time.
//
// Request channel (req_): one item per handshake; tuser carries the operation
// (cell write, cell read, field start, key press), tdata the operands.
// Response channel (rsp_): exactly one item per request, in order, giving the
// read data, cursor, field start, field length and end-of-session flags.
// Cell write, field start and cursor keys go through decode to the result
// stage; a read also waits for the registered RAM data. An insert or a delete
// also moves the cells between cursor and field end, one cell a cycle
// through the single screen RAM port pair. An insert that scrolls first
// moves the screen up one row and fills its last row with spaces. A new
// request is taken once the previous one has reached the response register.
// Reset: the screen RAM is swept to spaces, one cell a cycle; req_tready
// stays low until the sweep ends.
// A stalled response holds in its register; the next request may still be
// taken and waits for the register to free before its result is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module screen_field_line_editor
   import sfle_pkg::*;
#(
   parameter int SCREEN_COLS = 64,
   parameter int SCREEN_ROWS = 16,
   parameter int MAX_FIELD   = 240
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // address, char_code, field_start, field_length, cursor_offset,
   // key_class, program_running
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // op
   input  wire logic [OP_W-1:0]       req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // read_data, cursor_now, start_now, length_now, done_res, terminator,
   // break_request, cancel_auto
   output logic      [RSP_DATA_W-1:0] rsp_tdata
);

   cmd_type cmd;
   sts_type sts;

   sfle_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   sfle_dp #(
      .SCREEN_COLS (SCREEN_COLS),
      .SCREEN_ROWS (SCREEN_ROWS),
      .MAX_FIELD   (MAX_FIELD)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks the screen field line editor against a predictor of its own. A
// directed table covers the screen extremes, every key, field clamping,
// scrolling and insert limits. Random edit sessions and noise items follow,
// with random idling on both sides and one long response hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
   import sfle_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLS      = 64;
   localparam int ROWS      = 16;
   localparam int CELLS     = COLS * ROWS;
   localparam int FIELD_MAX = 240;
   localparam int N_RANDOM  = 1520;
   localparam int HOLD_LEN  = 3000;
   localparam longint CYCLE_LIMIT = 20_000_000;

   typedef struct {
      logic [7:0] rd;
      logic [9:0] cur;
      logic [9:0] st;
      logic [7:0] len;
      logic       done;
      logic [2:0] term;
      logic       brk;
      logic       cancel;
   } result_t;

   typedef struct {
      logic [OP_W-1:0]  op;
      logic [9:0]       addr;
      logic [7:0]       ch;
      logic [9:0]       fs;
      logic [7:0]       fl;
      logic [7:0]       co;
      logic [KEY_W-1:0] key;
      logic             run;
      bit               typed;
      result_t          res;
   } row_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [OP_W-1:0]       req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   logic [7:0] screen [CELLS];
   int         fld_start, fld_len, cursor;
   result_t    pending_q [$];
   row_t       table_q [$];
   int         errors, items_sent, results_seen, scrolls, session_ends;
   longint     cycles;
   bit         calm;

   screen_field_line_editor u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycles, pending_q.size());
         $display("testbench NOT OK");
         $finish;
      end
   end

   task automatic report(string what, int want, int got);
      errors++;
      $display("mismatch on result %0d: %s expected %0d got %0d",
               results_seen, what, want, got);
   endtask

   function automatic void shift_insert(logic [7:0] ch);
      int last;
      if (ch < PRINT_LO || ch > PRINT_HI || fld_len >= FIELD_MAX) return;
      last = fld_start + fld_len;
      if (last >= CELLS - 1) begin
         if (fld_start < COLS) return;
         for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
         for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = SPACE_CODE;
         fld_start -= COLS;
         cursor    -= COLS;
         last      -= COLS;
         scrolls++;
      end
      for (int i = last; i > cursor; i--) screen[i] = screen[i - 1];
      screen[cursor] = ch;
      cursor++;
      fld_len++;
   endfunction

   function automatic void close_gap();
      int last;
      last = fld_start + fld_len;
      if (last != cursor) begin
         for (int i = cursor; i < last; i++) screen[i] = screen[i + 1];
         fld_len--;
      end
   endfunction

   function automatic result_t edit_step(row_t it);
      result_t r;
      int      fs, fl, co, last, t;
      r = '{default: '0};
      case (it.op)
         OP_WRITE: screen[it.addr] = it.ch;
         OP_READ:  r.rd = screen[it.addr];
         OP_START: begin
            fs = it.fs;
            fl = it.fl;
            co = it.co;
            if (fs > CELLS - 1) fs = CELLS - 1;
            if (fl > FIELD_MAX) fl = FIELD_MAX;
            if (fl > CELLS - 1 - fs) fl = CELLS - 1 - fs;
            if (co > fl) co = fl;
            fld_start = fs;
            fld_len   = fl;
            cursor    = fs + co;
         end
         default: begin
            last = fld_start + fld_len;
            case (it.key)
               KEY_CHAR:  shift_insert(it.ch);
               KEY_ENTER: begin r.done = 1; r.term = TERM_ENTER; end
               KEY_PGUP:  begin r.done = 1; r.term = TERM_PGUP; end
               KEY_PGDN:  begin r.done = 1; r.term = TERM_PGDN; end
               KEY_BKSP: begin
                  if (cursor != fld_start) begin
                     cursor--;
                     close_gap();
                  end
               end
               KEY_DEL:   close_gap();
               KEY_LEFT:  if (cursor != fld_start) cursor--;
               KEY_RIGHT: if (cursor != last) cursor++;
               KEY_END:   cursor = last;
               KEY_HOME:  cursor = fld_start;
               KEY_UP: begin
                  if (cursor < fld_start + COLS) cursor = fld_start;
                  else cursor -= COLS;
               end
               KEY_DOWN: begin
                  t = cursor + COLS;
                  cursor = (t > last) ? last : t;
               end
               KEY_BREAK: begin
                  r.brk = it.run; r.cancel = 1; r.done = 1; r.term = TERM_ESCAPE;
               end
               KEY_ESCAPE: begin
                  r.cancel = 1; r.done = 1; r.term = TERM_ESCAPE;
               end
               default: ;
            endcase
         end
      endcase
      if (r.done) session_ends++;
      r.cur = cursor[9:0];
      r.st  = fld_start[9:0];
      r.len = fld_len[7:0];
      return r;
   endfunction

   task automatic send(row_t it);
      int      gap, pick;
      result_t r;
      pick = $urandom_range(0, 99);
      gap = (calm || pick < 70) ? 0 : (pick < 95) ? $urandom_range(1, 3)
                                                  : $urandom_range(20, 60);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.op;
      req_tdata  <= {7'd0, it.run, it.key, it.co, it.fl, it.fs, it.ch, it.addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = edit_step(it);
      pending_q.push_back(it.typed ? it.res : r);
      items_sent++;
   endtask

   function automatic row_t mk(logic [1:0] op, int addr, int ch, int fs, int fl, int co,
                               int key, int run);
      row_t it;
      it.op = op; it.addr = addr; it.ch = ch; it.fs = fs; it.fl = fl; it.co = co;
      it.key = key; it.run = run; it.typed = 0; it.res = '{default: '0};
      return it;
   endfunction

   function automatic void add(row_t it);
      table_q.push_back(it);
   endfunction

   function automatic void add_typed(row_t it, int rd, int cur, int st, int len, int done,
                                     int term, int brk, int cancel);
      it.typed = 1;
      it.res = '{rd, cur, st, len, done, term, brk, cancel};
      table_q.push_back(it);
   endfunction

   function automatic row_t any_item();
      row_t it;
      it = mk($urandom_range(0, 3), $urandom_range(0, 1023), $urandom_range(0, 255),
              $urandom_range(0, 1023), $urandom_range(0, 255), $urandom_range(0, 255),
              $urandom_range(0, 15), $urandom_range(0, 1));
      return it;
   endfunction

   // receiver: random stalls, one long hold-off
   initial begin
      int      stall;
      bit      held;
      result_t got, want;
      stall = 0;
      held  = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got.rd     = rsp_tdata[7:0];
            got.cur    = rsp_tdata[17:8];
            got.st     = rsp_tdata[27:18];
            got.len    = rsp_tdata[35:28];
            got.done   = rsp_tdata[36];
            got.term   = rsp_tdata[39:37];
            got.brk    = rsp_tdata[40];
            got.cancel = rsp_tdata[41];
            results_seen++;
            if (pending_q.size() == 0) begin
               report("unexpected result, none", 0, 1);
            end else begin
               want = pending_q.pop_front();
               if (got.rd !== want.rd) report("read_data", want.rd, got.rd);
               if (got.cur !== want.cur) report("cursor_now", want.cur, got.cur);
               if (got.st !== want.st) report("start_now", want.st, got.st);
               if (got.len !== want.len) report("length_now", want.len, got.len);
               if (got.done !== want.done) report("done_res", want.done, got.done);
               if (got.term !== want.term) report("terminator", want.term, got.term);
               if (got.brk !== want.brk) report("break_request", want.brk, got.brk);
               if (got.cancel !== want.cancel) report("cancel_auto", want.cancel, got.cancel);
            end
         end
         if (!held && items_sent >= 400) begin
            held = 1;
            rsp_tready <= 1'b0;
            repeat (HOLD_LEN) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!calm) begin
               case ($urandom_range(0, 99))
                  0, 1:          stall = $urandom_range(20, 60);
                  2, 3, 4, 5, 6: stall = $urandom_range(1, 3);
                  default:       stall = 0;
               endcase
            end
         end
      end
   end

   initial begin
      row_t it;
      int   n, keys, pick;
      for (int i = 0; i < CELLS; i++) screen[i] = SPACE_CODE;
      fld_start = 0; fld_len = 0; cursor = 0;
      errors = 0; items_sent = 0; results_seen = 0; scrolls = 0; session_ends = 0;
      cycles = 0; calm = 0;

      add_typed(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0), 32, 0, 0, 0, 0, TERM_NONE, 0, 0);
      add_typed(mk(OP_WRITE, 1023, 255, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0, TERM_NONE, 0, 0);
      add_typed(mk(OP_READ, 1023, 0, 0, 0, 0, 0, 0), 255, 0, 0, 0, 0, TERM_NONE, 0, 0);
      add_typed(mk(OP_WRITE, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0, TERM_NONE, 0, 0);
      add_typed(mk(OP_START, 0, 0, 1023, 255, 255, 0, 0), 0, 1023, 1023, 0, 0, TERM_NONE, 0, 0);
      add_typed(mk(OP_START, 0, 0, 0, 255, 255, 0, 0), 0, 240, 0, 240, 0, TERM_NONE, 0, 0);
      add_typed(mk(OP_KEY, 0, 0, 0, 0, 0, KEY_ENTER, 0), 0, 240, 0, 240, 1, TERM_ENTER, 0, 0);
      add_typed(mk(OP_KEY, 0, 0, 0, 0, 0, KEY_PGUP, 0), 0, 240, 0, 240, 1, TERM_PGUP, 0, 0);
      add_typed(mk(OP_KEY, 0, 0, 0, 0, 0, KEY_PGDN, 1), 0, 240, 0, 240, 1, TERM_PGDN, 0, 0);
      add_typed(mk(OP_KEY, 0, 0, 0, 0, 0, KEY_ESCAPE, 1), 0, 240, 0, 240, 1, TERM_ESCAPE, 0, 1);
      add_typed(mk(OP_KEY, 0, 0, 0, 0, 0, KEY_BREAK, 1), 0, 240, 0, 240, 1, TERM_ESCAPE, 1, 1);
      add_typed(mk(OP_KEY, 0, 0, 0, 0, 0, KEY_BREAK, 0), 0, 240, 0, 240, 1, TERM_ESCAPE, 0, 1);
      add_typed(mk(OP_KEY, 0, 0, 0, 0, 0, 14, 0), 0, 240, 0, 240, 0, TERM_NONE, 0, 0);
      add_typed(mk(OP_KEY, 0, 0, 0, 0, 0, 15, 1), 0, 240, 0, 240, 0, TERM_NONE, 0, 0);
      add_typed(mk(OP_KEY, 0, 65, 0, 0, 0, KEY_CHAR, 0), 0, 240, 0, 240, 0, TERM_NONE, 0, 0);
      add(mk(OP_START, 0, 0, 900, 123, 5, 0, 0));
      add(mk(OP_KEY, 0, 65, 0, 0, 0, KEY_CHAR, 0));
      add(mk(OP_KEY, 0, 126, 0, 0, 0, KEY_CHAR, 0));
      add(mk(OP_KEY, 0, 31, 0, 0, 0, KEY_CHAR, 0));
      add(mk(OP_KEY, 0, 127, 0, 0, 0, KEY_CHAR, 0));
      add(mk(OP_KEY, 0, 0, 0, 0, 0, KEY_BKSP, 0));
      add(mk(OP_KEY, 0, 0, 0, 0, 0, KEY_DEL, 0));
      add(mk(OP_KEY, 0, 0, 0, 0, 0, KEY_LEFT, 0));
      add(mk(OP_KEY, 0, 0, 0, 0, 0, KEY_RIGHT, 0));
      add(mk(OP_KEY, 0, 0, 0, 0, 0, KEY_DOWN, 0));
      add(mk(OP_KEY, 0, 0, 0, 0, 0, KEY_END, 0));
      add(mk(OP_KEY, 0, 0, 0, 0, 0, KEY_DEL, 0));
      add(mk(OP_KEY, 0, 0, 0, 0, 0, KEY_UP, 0));
      add(mk(OP_KEY, 0, 0, 0, 0, 0, KEY_HOME, 0));
      add(mk(OP_KEY, 0, 0, 0, 0, 0, KEY_BKSP, 0));
      add(mk(OP_READ, 900, 0, 0, 0, 0, 0, 0));

      @(negedge reset);
      @(posedge clock);
      foreach (table_q[i]) send(table_q[i]);

      n = 0;
      while (n < N_RANDOM) begin
         calm = (n >= 700 && n < 850);
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            send(any_item());
            n++;
         end else begin
            if (pick < 50) begin
               it = mk(OP_START, 0, 0, $urandom_range(800, 1023), $urandom_range(150, 255),
                       $urandom_range(0, 255), 0, 0);
            end else begin
               it = mk(OP_START, 0, 0, $urandom_range(0, 1023), $urandom_range(0, 255),
                       $urandom_range(0, 255), 0, 0);
            end
            send(it);
            n++;
            keys = $urandom_range(5, 30);
            for (int k = 0; k < keys && n < N_RANDOM; k++) begin
               it = any_item();
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4: begin
                     it.op = OP_KEY;
                     it.key = KEY_CHAR;
                     if ($urandom_range(0, 9) != 0) it.ch = $urandom_range(32, 126);
                  end
                  5: begin
                     it.op = OP_READ;
                     it.addr = (fld_start + $urandom_range(0, 250)) % CELLS;
                  end
                  default: it.op = OP_KEY;
               endcase
               send(it);
               n++;
            end
         end
      end
      calm = 0;
      @(posedge clock);
      req_tvalid <= 1'b0;

      while (pending_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("ran %0d items and checked %0d results: %0d scrolls, %0d session ends",
               items_sent, results_seen, scrolls, session_ends);
      $display("mismatches counted: %0d", errors);
      if (errors == 0 && pending_q.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
hdl/sfle_pkg.sv
hdl/sfle_ram.sv
hdl/sfle_ctrl.sv
hdl/sfle_dp.sv
hdl/screen_field_line_editor.sv
tb/sv/testbench.sv
